FILE: design/version_string_parse_compare_defines.svh
// Assertion macros used by the checker file of the version string block.
`ifndef VERSION_STRING_PARSE_COMPARE_DEFINES_SVH
`define VERSION_STRING_PARSE_COMPARE_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define VSPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define VSPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/vspc_pkg.sv
// Types and constants of the version string parse and compare block.
package vspc_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned PART_W  = 17;
    localparam int unsigned ORDER_W = 2;

    // Character codes the parser looks for
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LC_V = 8'h76;
    localparam logic [CHAR_W-1:0] CHAR_UC_V = 8'h56;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [3:0] DEC_BASE      = 4'd10;
    localparam logic [1:0] LAST_PART_IDX = 2'd2;

    // Comparison result codes
    localparam logic signed [ORDER_W-1:0] ORDER_NEWER  = 2'sb01;
    localparam logic signed [ORDER_W-1:0] ORDER_SAME   = 2'sb00;
    localparam logic signed [ORDER_W-1:0] ORDER_OLDER  = 2'sb11;
    localparam logic signed [ORDER_W-1:0] ORDER_UNUSED = 2'sb10;

    typedef enum logic [2:0] {
        PH_START,
        PH_NEED,
        PH_DIGITS,
        PH_FAILED
    } t_phase;

    // Byte handed from the input stage to the parser
    typedef struct packed {
        logic              step;
        logic [CHAR_W-1:0] char_code;
    } t_parse_ctl;

endpackage

FILE: design/vspc_if.sv
// Handshake interfaces for the byte input channel and the result channel.
interface vspc_in_if;
    logic                        valid;
    logic                        ready;
    logic [vspc_pkg::CHAR_W-1:0] char_code;
    logic                        second_of_pair;

    modport source (output valid, output char_code, output second_of_pair, input ready);
    modport sink   (input valid, input char_code, input second_of_pair, output ready);
endinterface

interface vspc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                valid_res;
    logic [vspc_pkg::PART_W-1:0]         part_major;
    logic [vspc_pkg::PART_W-1:0]         part_minor;
    logic [vspc_pkg::PART_W-1:0]         part_patch;
    logic signed [vspc_pkg::ORDER_W-1:0] order;

    modport source (output valid, output valid_res, output part_major, output part_minor,
                    output part_patch, output order, input ready);
    modport sink   (input valid, input valid_res, input part_major, input part_minor,
                    input part_patch, input order, output ready);
endinterface

FILE: design/version_string_parse_compare.sv
// Top level of the version string parser with first/second string compare.
//
//  channel   dir  payload                                               word
//  i_in      in   char_code[7:0], second_of_pair                        one byte
//  o_out     out  valid_res, part_major/minor/patch[16:0], order[1:0]   one per zero byte
//
//  One byte per cycle sustained while no zero byte waits on a stalled result; a byte sits in
//  the input register and its result, if any, is then registered in the output register.
//  The parser does the multiply-by-ten accumulate for each byte combinationally.
//  Synchronous active-low reset clears the parse phase and part index and the valid flag of the stored first string.
//  A zero byte waits in the input register only while a result is stalled in the
//  output register; other bytes always pass.
module version_string_parse_compare #(
    parameter int unsigned PART_LIMIT = 99999
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vspc_in_if.sink    i_in,
    vspc_out_if.source o_out
);

    localparam int unsigned ACC_W  = $clog2(PART_LIMIT + 1);
    localparam int unsigned WIDE_W = (ACC_W > vspc_pkg::PART_W) ? ACC_W : vspc_pkg::PART_W;

    logic                          r_in_valid;
    logic [vspc_pkg::CHAR_W-1:0]   r_in_char;
    logic                          r_in_second;
    logic                          in_accept;
    logic                          advance;
    logic                          term;

    vspc_pkg::t_parse_ctl          parse_ctl;
    logic                          str_valid;
    logic [ACC_W-1:0]              major, minor, patch;

    logic [ACC_W-1:0]              r_first_major, r_first_minor, r_first_patch;
    logic                          r_first_valid;
    logic signed [vspc_pkg::ORDER_W-1:0] n_order;

    logic                          r_out_valid;
    logic                          r_res_valid;
    logic [vspc_pkg::PART_W-1:0]   r_major, r_minor, r_patch;
    logic signed [vspc_pkg::ORDER_W-1:0] r_order;

    logic [WIDE_W-1:0]             wide_major, wide_minor, wide_patch;

    // Pass non-terminators always; a terminator needs a free output slot
    assign advance    = r_in_valid &&
                        ((r_in_char != vspc_pkg::CHAR_NUL) || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_accept  = i_in.valid && i_in.ready;
    assign term       = advance && (r_in_char == vspc_pkg::CHAR_NUL);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char   <= i_in.char_code;
            r_in_second <= i_in.second_of_pair;
        end
    end

    assign parse_ctl.step      = advance;
    assign parse_ctl.char_code = r_in_char;

    vspc_parser #(
        .PART_LIMIT (PART_LIMIT),
        .ACC_W      (ACC_W)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (parse_ctl),
        .o_str_valid (str_valid),
        .o_major     (major),
        .o_minor     (minor),
        .o_patch     (patch)
    );

    // Compare against the stored first string, most significant part first
    always_comb begin
        n_order = vspc_pkg::ORDER_SAME;
        if (r_in_second) begin
            if (!str_valid || !r_first_valid) begin
                n_order = vspc_pkg::ORDER_OLDER;
            end else if (major > r_first_major) begin
                n_order = vspc_pkg::ORDER_NEWER;
            end else if (major < r_first_major) begin
                n_order = vspc_pkg::ORDER_OLDER;
            end else if (minor > r_first_minor) begin
                n_order = vspc_pkg::ORDER_NEWER;
            end else if (minor < r_first_minor) begin
                n_order = vspc_pkg::ORDER_OLDER;
            end else if (patch > r_first_patch) begin
                n_order = vspc_pkg::ORDER_NEWER;
            end else if (patch < r_first_patch) begin
                n_order = vspc_pkg::ORDER_OLDER;
            end
        end
    end

    // Store a first string on its terminator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_valid <= 1'b0;
        end else if (term && !r_in_second) begin
            r_first_valid <= str_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (term && !r_in_second) begin
            r_first_major <= major;
            r_first_minor <= minor;
            r_first_patch <= patch;
        end
    end

    // Fit parts to the output field width
    assign wide_major = WIDE_W'(major);
    assign wide_minor = WIDE_W'(minor);
    assign wide_patch = WIDE_W'(patch);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= term || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (term) begin
            r_res_valid <= str_valid;
            r_major     <= wide_major[vspc_pkg::PART_W-1:0];
            r_minor     <= wide_minor[vspc_pkg::PART_W-1:0];
            r_patch     <= wide_patch[vspc_pkg::PART_W-1:0];
            r_order     <= n_order;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.valid_res  = r_res_valid;
    assign o_out.part_major = r_major;
    assign o_out.part_minor = r_minor;
    assign o_out.part_patch = r_patch;
    assign o_out.order      = r_order;

endmodule

FILE: design/vspc_parser.sv
// Per-byte version string parser: phase, part index, accumulator and finished parts.
module vspc_parser #(
    parameter int unsigned PART_LIMIT = 99999,
    parameter int unsigned ACC_W      = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vspc_pkg::t_parse_ctl i_ctl,
    output logic                 o_str_valid,
    output logic [ACC_W-1:0]     o_major,
    output logic [ACC_W-1:0]     o_minor,
    output logic [ACC_W-1:0]     o_patch
);

    localparam int unsigned       PROD_W  = ACC_W + 4;
    localparam logic [PROD_W-1:0] LIMIT_W = PROD_W'(PART_LIMIT);

    vspc_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_idx, n_idx;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] r_fin0, n_fin0;
    logic [ACC_W-1:0] r_fin1, n_fin1;

    logic [vspc_pkg::CHAR_W-1:0] c;
    logic [vspc_pkg::CHAR_W-1:0] c_off;
    logic                        is_digit;
    logic                        is_v;
    logic [PROD_W-1:0]           digit_w;
    logic [PROD_W-1:0]           prod;
    vspc_pkg::t_phase            phase_in;

    // Decode the byte
    assign c        = i_ctl.char_code;
    assign c_off    = c - vspc_pkg::CHAR_ZERO;
    assign is_digit = (c >= vspc_pkg::CHAR_ZERO) && (c <= vspc_pkg::CHAR_NINE);
    assign is_v     = (c == vspc_pkg::CHAR_LC_V) || (c == vspc_pkg::CHAR_UC_V);
    assign digit_w  = PROD_W'(c_off[3:0]);
    assign prod     = PROD_W'(r_acc) * PROD_W'(vspc_pkg::DEC_BASE) + digit_w;
    assign phase_in = (r_phase == vspc_pkg::PH_START) ? vspc_pkg::PH_NEED : r_phase;

    // Advance the parse state by one byte
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_fin0  = r_fin0;
        n_fin1  = r_fin1;
        if (i_ctl.step) begin
            if (c == vspc_pkg::CHAR_NUL) begin
                n_phase = vspc_pkg::PH_START;
                n_idx   = 2'd0;
            end else if ((r_phase == vspc_pkg::PH_START) && is_v) begin
                n_phase = vspc_pkg::PH_NEED;
            end else begin
                unique case (phase_in)
                    vspc_pkg::PH_NEED: begin
                        if (is_digit) begin
                            n_acc   = ACC_W'(digit_w);
                            n_phase = (digit_w > LIMIT_W) ? vspc_pkg::PH_FAILED
                                                          : vspc_pkg::PH_DIGITS;
                        end else begin
                            n_phase = vspc_pkg::PH_FAILED;
                        end
                    end
                    vspc_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                            n_acc = ACC_W'(prod);
                            if (prod > LIMIT_W) begin
                                n_phase = vspc_pkg::PH_FAILED;
                            end
                        end else if ((c == vspc_pkg::CHAR_DOT) &&
                                     (r_idx < vspc_pkg::LAST_PART_IDX)) begin
                            if (r_idx[0]) begin
                                n_fin1 = r_acc;
                            end else begin
                                n_fin0 = r_acc;
                            end
                            n_idx   = r_idx + 2'd1;
                            n_phase = vspc_pkg::PH_NEED;
                        end else begin
                            n_phase = vspc_pkg::PH_FAILED;
                        end
                    end
                    default: n_phase = vspc_pkg::PH_FAILED;
                endcase
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= vspc_pkg::PH_START;
            r_idx   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_fin0 <= n_fin0;
        r_fin1 <= n_fin1;
    end

    // Report the string as it stands before the terminator
    assign o_str_valid = (r_phase == vspc_pkg::PH_DIGITS) && (r_idx == vspc_pkg::LAST_PART_IDX);
    assign o_major     = o_str_valid ? r_fin0 : '0;
    assign o_minor     = o_str_valid ? r_fin1 : '0;
    assign o_patch     = o_str_valid ? r_acc  : '0;

endmodule

FILE: design/vspc_checker.sv
// Port-level checks on the result channel of the version string block.
`include "version_string_parse_compare_defines.svh"

module vspc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic                                i_valid_res,
    input logic [vspc_pkg::PART_W-1:0]         i_part_major,
    input logic [vspc_pkg::PART_W-1:0]         i_part_minor,
    input logic [vspc_pkg::PART_W-1:0]         i_part_patch,
    input logic signed [vspc_pkg::ORDER_W-1:0] i_order
);

    // Hold a stalled result word
    `VSPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_valid_res) && $stable(i_part_major) && $stable(i_part_minor) && $stable(i_part_patch) && $stable(i_order), "result word changed while stalled")

    // Drop parts and never claim newer for a malformed string
    `VSPC_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, i_out_valid && !i_valid_res, (i_part_major == '0) && (i_part_minor == '0) && (i_part_patch == '0) && (i_order != vspc_pkg::ORDER_NEWER), "invalid string with nonzero parts or newer order")

    // Never emit the unused order code
    `VSPC_ASSERT_NOW(a_order_code, i_clk, i_rst_n, i_out_valid, i_order != vspc_pkg::ORDER_UNUSED, "order carries unused code")

    // Equal order with a nonzero major part only for a valid string
    `VSPC_ASSERT_NOW(a_same_valid, i_clk, i_rst_n, i_out_valid && (i_order == vspc_pkg::ORDER_SAME) && (i_part_major != '0), i_valid_res, "equal order with parts on an invalid string")

endmodule

bind version_string_parse_compare vspc_checker u_vspc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_valid_res  (o_out.valid_res),
    .i_part_major (o_out.part_major),
    .i_part_minor (o_out.part_minor),
    .i_part_patch (o_out.part_patch),
    .i_order      (o_out.order)
);
